/* design/pwc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwc_pkg
// Shared constants, types and byte classification for the palindrome word
// counter.
// ----------------------------------------------------------------------------
package pwc_pkg;

   localparam int MAX_WORD_LEN = 128;
   localparam int ADDR_W       = $clog2(MAX_WORD_LEN);
   localparam int LEN_W        = $clog2(MAX_WORD_LEN + 1);
   localparam int CHAR_W       = 8;
   localparam int COUNT_W      = 32;

   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PERIOD  = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_COMMA   = 8'h2C;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LOW_A   = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOW_Z   = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_UP_A    = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UP_Z    = 8'h5A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

   // controller -> datapath
   typedef struct packed {
      logic store_byte;   // word byte: store and update length/invalid
      logic skip_delim;   // delimiter that closes nothing
      logic start_walk;   // load the end pointers for the check
      logic issue_read;   // read the next pair from both ends
      logic step_lo;      // pair matched, move the low pointer on
      logic emit;         // load the result register
      logic ended;        // result closes a word
      logic counted;      // result counts a palindrome
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_delim;
      logic prev_delim;
      logic invalid;
      logic more_pairs;
      logic pair_match;
      logic rsp_busy;
   } status_type;

   function automatic logic is_delim(input logic [CHAR_W-1:0] b);
      return (b == CHAR_SPACE) || (b == CHAR_PERIOD) || (b == CHAR_COMMA) ||
             (b == CHAR_NEWLINE) || (b == CHAR_TAB);
   endfunction

   function automatic logic is_letter(input logic [CHAR_W-1:0] b);
      return ((b >= CHAR_LOW_A) && (b <= CHAR_LOW_Z)) ||
             ((b >= CHAR_UP_A) && (b <= CHAR_UP_Z));
   endfunction

   function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] b);
      return ((b >= CHAR_LOW_A) && (b <= CHAR_LOW_Z)) ? b - CASE_OFFSET : b;
   endfunction

endpackage

/* design/palindrome_word_counter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palindrome_word_counter
// Counts case-insensitive palindrome words in a byte stream, one result
// beat for every input beat.
// ----------------------------------------------------------------------------
//  channel | ports                                        | direction
//  req     | req_valid, req_stall, req_char_in            | in
//  rsp     | rsp_valid, rsp_stall, rsp_palindrome_count,  | out
//          | rsp_word_ended, rsp_word_is_palindrome       |
//
// Word bytes and delimiters that close no valid word are answered from
// idle directly. Closing a valid word walks it pair by pair from both
// ends until all pairs match or a pair mismatches: the sequencer reads
// one pair from the word buffer, then compares it.
// Synchronous reset clears lengths, flags, count and the result valid bit;
// the word buffer is not cleared. A new beat is taken only in idle and
// while the result register is empty or being drained.
// ----------------------------------------------------------------------------
module palindrome_word_counter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [pwc_pkg::CHAR_W-1:0]  req_char_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [pwc_pkg::COUNT_W-1:0] rsp_palindrome_count,
   output logic                        rsp_word_ended,
   output logic                        rsp_word_is_palindrome
);

   pwc_pkg::cmd_type    cmd;
   pwc_pkg::status_type status;

   pwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pwc_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .req_char_in            (req_char_in),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_palindrome_count   (rsp_palindrome_count),
      .rsp_word_ended         (rsp_word_ended),
      .rsp_word_is_palindrome (rsp_word_is_palindrome),
      .cmd                    (cmd),
      .status                 (status)
   );

endmodule

/* design/pwc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwc_ctrl
// Sequencer: classifies each beat and walks the stored word pair by pair
// when a valid word is closed.
// ----------------------------------------------------------------------------
module pwc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pwc_pkg::status_type status,
   output pwc_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_CMP  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      take;

   assign req_stall = (state_ff != ST_IDLE) || status.rsp_busy;
   assign take      = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               priority if (!status.is_delim) begin
                  cmd.store_byte = 1'b1;
                  cmd.emit       = 1'b1;
               end else if (status.prev_delim) begin
                  cmd.skip_delim = 1'b1;
                  cmd.emit       = 1'b1;
               end else if (status.invalid) begin
                  cmd.emit  = 1'b1;
                  cmd.ended = 1'b1;
               end else begin
                  cmd.start_walk = 1'b1;
                  state_in       = ST_READ;
               end
            end
         end
         ST_READ: begin
            if (status.more_pairs) begin
               cmd.issue_read = 1'b1;
               state_in       = ST_CMP;
            end else begin
               cmd.emit    = 1'b1;
               cmd.ended   = 1'b1;
               cmd.counted = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_CMP: begin
            if (status.pair_match) begin
               cmd.step_lo = 1'b1;
               state_in    = ST_READ;
            end else begin
               cmd.emit  = 1'b1;
               cmd.ended = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/pwc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwc_datapath
// Word buffer, length and flag registers, end pointers, pair compare,
// running count and the result register.
// ----------------------------------------------------------------------------
module pwc_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [pwc_pkg::CHAR_W-1:0]     req_char_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [pwc_pkg::COUNT_W-1:0]    rsp_palindrome_count,
   output logic                           rsp_word_ended,
   output logic                           rsp_word_is_palindrome,
   input  pwc_pkg::cmd_type               cmd,
   output pwc_pkg::status_type            status
);

   logic [pwc_pkg::CHAR_W-1:0]  word_mem [pwc_pkg::MAX_WORD_LEN];
   logic [pwc_pkg::CHAR_W-1:0]  rd_lo_ff, rd_hi_ff;

   logic [pwc_pkg::LEN_W-1:0]   len_ff, len_in;
   logic                        invalid_ff, invalid_in;
   logic                        prev_delim_ff, prev_delim_in;
   logic [pwc_pkg::LEN_W-1:0]   lo_ff, lo_in;
   logic [pwc_pkg::LEN_W-1:0]   hi_ff, hi_in;
   logic [pwc_pkg::LEN_W-1:0]   hi_dec;
   logic [pwc_pkg::COUNT_W-1:0] total_ff, total_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        ended_ff, counted_ff;
   logic                        len_full;

   assign len_full = (len_ff == pwc_pkg::LEN_W'(pwc_pkg::MAX_WORD_LEN));
   assign hi_dec   = hi_ff - pwc_pkg::LEN_W'(1);

   assign status.is_delim   = pwc_pkg::is_delim(req_char_in);
   assign status.prev_delim = prev_delim_ff;
   assign status.invalid    = invalid_ff;
   assign status.more_pairs = ({1'b0, lo_ff} + (pwc_pkg::LEN_W + 1)'(1)) < {1'b0, hi_ff};
   assign status.pair_match = pwc_pkg::fold_case(rd_lo_ff) == pwc_pkg::fold_case(rd_hi_ff);
   assign status.rsp_busy   = rsp_valid_ff && rsp_stall;

   always_comb begin
      len_in        = len_ff;
      invalid_in    = invalid_ff;
      prev_delim_in = prev_delim_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (cmd.store_byte) begin
         prev_delim_in = 1'b0;
         if (!pwc_pkg::is_letter(req_char_in) || len_full) begin
            invalid_in = 1'b1;
         end
         if (!len_full) begin
            len_in = len_ff + pwc_pkg::LEN_W'(1);
         end
      end
      if (cmd.skip_delim) begin
         prev_delim_in = 1'b1;
      end
      if (cmd.start_walk) begin
         lo_in = '0;
         hi_in = len_ff;
      end
      if (cmd.issue_read) begin
         hi_in = hi_dec;
      end
      if (cmd.step_lo) begin
         lo_in = lo_ff + pwc_pkg::LEN_W'(1);
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (cmd.ended) begin
            len_in        = '0;
            invalid_in    = 1'b0;
            prev_delim_in = 1'b1;
         end
         // count holds once it reaches all ones
         if (cmd.counted && (total_ff != '1)) begin
            total_in = total_ff + pwc_pkg::COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         invalid_ff    <= 1'b0;
         prev_delim_ff <= 1'b1;
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         len_ff        <= len_in;
         invalid_ff    <= invalid_in;
         prev_delim_ff <= prev_delim_in;
         total_ff      <= total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (cmd.emit) begin
         ended_ff   <= cmd.ended;
         counted_ff <= cmd.counted;
      end
   end

   // word buffer: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.store_byte && !len_full) begin
         word_mem[len_ff[pwc_pkg::ADDR_W-1:0]] <= req_char_in;
      end
      if (cmd.issue_read) begin
         rd_lo_ff <= word_mem[lo_ff[pwc_pkg::ADDR_W-1:0]];
         rd_hi_ff <= word_mem[hi_dec[pwc_pkg::ADDR_W-1:0]];
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_palindrome_count   = total_ff;
   assign rsp_word_ended         = ended_ff;
   assign rsp_word_is_palindrome = counted_ff;

endmodule

/* design/pwc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwc_checker
// Port-level checks for the palindrome word counter, bound to the top level.
// ----------------------------------------------------------------------------
module pwc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [pwc_pkg::COUNT_W-1:0] rsp_palindrome_count,
   input logic                        rsp_word_ended,
   input logic                        rsp_word_is_palindrome
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_palindrome_count) &&
         $stable(rsp_word_ended) && $stable(rsp_word_is_palindrome))
      else $error("result beat changed while stalled");

   a_counted_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word_is_palindrome |-> rsp_word_ended)
      else $error("palindrome flagged without a closed word");

   a_counted_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word_is_palindrome |-> rsp_palindrome_count != '0)
      else $error("palindrome counted but count is zero");

   // a full result register blocks the input side
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while result register is held");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind palindrome_word_counter pwc_checker u_pwc_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_stall              (req_stall),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_palindrome_count   (rsp_palindrome_count),
   .rsp_word_ended         (rsp_word_ended),
   .rsp_word_is_palindrome (rsp_word_is_palindrome)
);
